// ----- rtl/core/ssfc_pkg.sv -----
// Shared types, register codes and float helper functions for the strided
// sample fetch and convert unit. No dependencies.
`timescale 1ns / 1ps

package ssfc_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] sample_index;
    logic [63:0] raw_element;
  } in_item_t;

  typedef struct packed {
    logic        is_value;
    logic [63:0] byte_address;
    logic        beyond_count;
    logic [31:0] value_bits;
  } out_item_t;

  localparam logic [2:0] REG_FORMAT = 3'd0;
  localparam logic [2:0] REG_FIRST  = 3'd1;
  localparam logic [2:0] REG_STRIDE = 3'd2;
  localparam logic [2:0] REG_HEADER = 3'd3;
  localparam logic [2:0] REG_COUNT  = 3'd4;
  localparam logic [2:0] REG_GAIN   = 3'd5;
  localparam logic [2:0] REG_BIAS   = 3'd6;

  localparam logic [2:0] FMT_F32 = 3'd0;
  localparam logic [2:0] FMT_F64 = 3'd1;
  localparam logic [2:0] FMT_S8  = 3'd2;
  localparam logic [2:0] FMT_U8  = 3'd3;
  localparam logic [2:0] FMT_S16 = 3'd4;
  localparam logic [2:0] FMT_U16 = 3'd5;
  localparam logic [2:0] FMT_S32 = 3'd6;
  localparam logic [2:0] FMT_U32 = 3'd7;

  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

  // Log2 of the element size in bytes.
  function automatic logic [1:0] size_shift(logic [2:0] fmt);
    logic [1:0] s;
    case (fmt)
      FMT_F32: s = 2'd2;
      FMT_F64: s = 2'd3;
      FMT_S8:  s = 2'd0;
      FMT_U8:  s = 2'd0;
      FMT_S16: s = 2'd1;
      FMT_U16: s = 2'd1;
      FMT_S32: s = 2'd2;
      default: s = 2'd2;
    endcase
    return s;
  endfunction

  // Position of the leading one of a 48-bit significand.
  function automatic logic [5:0] lead48(logic [47:0] s);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (s[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Round a significand normalized to bit 47 with biased exponent e, nearest even.
  // Exponents below one take the subnormal path; the carry of rounding runs into
  // the exponent field.
  function automatic logic [31:0] round_pack(logic sign, logic [47:0] n,
                                             logic signed [11:0] e);
    logic [5:0]   rsh;
    logic [111:0] x;
    logic [47:0]  t;
    logic         st;
    logic         up;
    logic [7:0]   pexp;
    logic [30:0]  bits;
    if (e >= 12'sd255) return {sign, 8'hFF, 23'd0};
    if (e >= 12'sd1) begin
      rsh  = 6'd0;
      pexp = e[7:0] - 8'd1;
    end else begin
      rsh  = (e < -12'sd61) ? 6'd63 : 6'(12'sd1 - e);
      pexp = 8'd0;
    end
    x    = {n, 64'd0} >> rsh;
    t    = x[111:64];
    st   = (|t[22:0]) | (|x[63:0]);
    up   = t[23] & (st | t[24]);
    bits = {pexp, 23'd0} + {7'd0, t[47:24]} + {30'd0, up};
    return {sign, bits};
  endfunction

  function automatic logic [31:0] int_to_f32(logic neg, logic [31:0] mag);
    logic [4:0]  p;
    logic [31:0] m;
    logic        up;
    logic [30:0] bits;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    if (mag == 32'd0) return 32'd0;
    m    = mag << (5'd31 - p);
    up   = m[7] & ((|m[6:0]) | m[8]);
    bits = {8'(8'd126 + {3'd0, p}), 23'd0} + {7'd0, m[31:8]} + {30'd0, up};
    return {neg, bits};
  endfunction

  function automatic logic [31:0] f64_to_f32(logic [63:0] d);
    logic               sign;
    logic [10:0]        ex;
    logic [51:0]        man;
    logic signed [11:0] fe;
    logic [5:0]         shr;
    logic [7:0]         pexp;
    logic [116:0]       x;
    logic               up;
    logic [30:0]        bits;
    sign = d[63];
    ex   = d[62:52];
    man  = d[51:0];
    if (ex == 11'h7FF) return (man != 52'd0) ? QNAN : {sign, 8'hFF, 23'd0};
    if (ex == 11'd0) return {sign, 31'd0};
    fe = $signed({1'b0, ex}) - 12'sd896;
    if (fe >= 12'sd255) return {sign, 8'hFF, 23'd0};
    if (fe < -12'sd24) return {sign, 31'd0};
    if (fe >= 12'sd1) begin
      shr  = 6'd29;
      pexp = fe[7:0] - 8'd1;
    end else begin
      shr  = 6'(12'sd30 - fe);
      pexp = 8'd0;
    end
    x    = {1'b1, man, 64'd0} >> shr;
    up   = x[63] & ((|x[62:0]) | x[64]);
    bits = {pexp, 23'd0} + x[94:64] + {30'd0, up};
    return {sign, bits};
  endfunction

  function automatic logic [31:0] convert_raw(logic [2:0] fmt, logic [63:0] raw);
    logic [31:0] r;
    case (fmt)
      FMT_F32: r = raw[31:0];
      FMT_F64: r = f64_to_f32(raw);
      FMT_S8:  r = int_to_f32(raw[7], raw[7] ? 32'(9'h100 - {1'b0, raw[7:0]})
                                              : {24'd0, raw[7:0]});
      FMT_U8:  r = int_to_f32(1'b0, {24'd0, raw[7:0]});
      FMT_S16: r = int_to_f32(raw[15], raw[15] ? 32'(17'h10000 - {1'b0, raw[15:0]})
                                                : {16'd0, raw[15:0]});
      FMT_U16: r = int_to_f32(1'b0, {16'd0, raw[15:0]});
      FMT_S32: r = int_to_f32(raw[31], raw[31] ? (~raw[31:0] + 32'd1) : raw[31:0]);
      default: r = int_to_f32(1'b0, raw[31:0]);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/strided_sample_fetch_convert_unit.sv -----
// Top level of the strided sample fetch and convert unit: configuration
// registers, a seven-stage pipeline for address and float paths.
// Depends on ssfc_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_ready   ssfc_pkg::in_item_t (kind, index, raw element)
// out_      output     out_valid/out_ready ssfc_pkg::out_item_t (one result per request)
// cfg_      input      cfg_valid/cfg_ready 3-bit register index, 32-bit write data
//
// Every request passes seven register stages, and a new request may enter in
// every cycle unless the output stall holds the pipeline. The
// depth is set by the float path: format conversion, significand multiply,
// normalize, round, align and add, normalize, and round into the output register.
// The synchronous active-low reset clears the valid bits and loads the register
// defaults. When the output register holds a result that is not taken, the whole
// pipeline holds, so nothing is lost or repeated; in_ready drops in exactly those
// cycles.

module strided_sample_fetch_convert_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssfc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssfc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  // Configuration registers.
  logic [2:0]  format_r;
  logic [31:0] first_r;
  logic [15:0] stride_r;
  logic [31:0] header_r;
  logic [31:0] count_r;
  logic [31:0] gain_r;
  logic [31:0] bias_r;

  // Writes are always taken; users write only while the pipeline is empty (unenforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= ssfc_pkg::FMT_F32;
      first_r  <= '0;
      stride_r <= 16'd1;
      header_r <= '0;
      count_r  <= '0;
      gain_r   <= ssfc_pkg::ONE_BITS;
      bias_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssfc_pkg::REG_FORMAT: format_r <= cfg_data[2:0];
        ssfc_pkg::REG_FIRST:  first_r  <= cfg_data;
        ssfc_pkg::REG_STRIDE: stride_r <= cfg_data[15:0];
        ssfc_pkg::REG_HEADER: header_r <= cfg_data;
        ssfc_pkg::REG_COUNT:  count_r  <= cfg_data;
        ssfc_pkg::REG_GAIN:   gain_r   <= cfg_data;
        ssfc_pkg::REG_BIAS:   bias_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // One enable for all stages: advance unless the output holds an untaken result.
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;

  // Valid bits and the fields every stage carries.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic k1_r, k2_r, k3_r, k4_r, k5_r, k6_r;
  logic r1_r, r2_r, r3_r, r4_r, r5_r, r6_r;

  // Stage 1: element conversion, index times stride and range check.
  logic [31:0] x1_r;
  logic [47:0] ip1_r;

  // Stage 2: product significand; element index.
  logic [63:0]        el2_r;
  logic               ms2_r;
  logic               msp2_r;
  logic [31:0]        msb2_r;
  logic [47:0]        mp2_r;
  logic signed [11:0] me2_r;

  // Stage 3: normalized product; byte address.
  logic [63:0]        a3_r, a4_r, a5_r, a6_r;
  logic               ms3_r;
  logic               msp3_r;
  logic [31:0]        msb3_r;
  logic [47:0]        mn3_r;
  logic signed [11:0] mne3_r;

  // Stage 4: rounded product.
  logic [31:0] p4_r;

  // Stage 5: aligned sum; stage 6: normalized sum.
  logic               as5_r, as6_r;
  logic               asp5_r, asp6_r;
  logic [31:0]        asb5_r, asb6_r;
  logic [47:0]        s5_r;
  logic signed [11:0] ae5_r;
  logic [47:0]        n6_r;
  logic signed [11:0] ne6_r;

  ssfc_pkg::out_item_t out_data_r;
  assign out_data = out_data_r;

  // Multiply operand decode.
  logic [7:0]         mxe, mge;
  logic               mx_nan, mg_nan, mx_inf, mg_inf, mx_zero, mg_zero, m_sign;
  logic               m_spec;
  logic [31:0]        m_specb;
  logic [23:0]        mxm, mgm;
  logic signed [11:0] m_ebase;

  always_comb begin
    mxe     = x1_r[30:23];
    mge     = gain_r[30:23];
    mx_nan  = (&mxe) && (|x1_r[22:0]);
    mg_nan  = (&mge) && (|gain_r[22:0]);
    mx_inf  = (&mxe) && !(|x1_r[22:0]);
    mg_inf  = (&mge) && !(|gain_r[22:0]);
    mx_zero = (x1_r[30:0] == 31'd0);
    mg_zero = (gain_r[30:0] == 31'd0);
    m_sign  = x1_r[31] ^ gain_r[31];
    mxm     = {mxe != 8'd0, x1_r[22:0]};
    mgm     = {mge != 8'd0, gain_r[22:0]};
    // Subnormals sit at exponent one with no hidden bit.
    m_ebase = $signed({4'd0, (mxe == 8'd0) ? 8'd1 : mxe})
            + $signed({4'd0, (mge == 8'd0) ? 8'd1 : mge}) - 12'sd173;
    m_spec  = 1'b1;
    if (mx_nan || mg_nan || (mx_inf && mg_zero) || (mg_inf && mx_zero)) begin
      m_specb = ssfc_pkg::QNAN;
    end else if (mx_inf || mg_inf) begin
      m_specb = {m_sign, 8'hFF, 23'd0};
    end else if (mx_zero || mg_zero) begin
      m_specb = {m_sign, 31'd0};
    end else begin
      m_spec  = 1'b0;
      m_specb = 32'd0;
    end
  end

  // Stage 3 normalize of the product.
  logic [5:0] m_lead;
  assign m_lead = ssfc_pkg::lead48(mp2_r);

  // Add operand decode: the larger magnitude goes first, the other is aligned
  // with guard, round and sticky bits below the significand.
  logic [31:0]        aa, ab;
  logic [7:0]         aae, abe, ad;
  logic [4:0]         adc;
  logic [23:0]        aam, abm;
  logic [58:0]        abx;
  logic [26:0]        absh;
  logic [27:0]        asum;
  logic               a_nan, b_nan, a_inf, b_inf;
  logic               a_spec;
  logic [31:0]        a_specb;

  always_comb begin
    if (p4_r[30:0] >= bias_r[30:0]) begin
      aa = p4_r;
      ab = bias_r;
    end else begin
      aa = bias_r;
      ab = p4_r;
    end
    a_nan = (&p4_r[30:23]) && (|p4_r[22:0]);
    b_nan = (&bias_r[30:23]) && (|bias_r[22:0]);
    a_inf = (&p4_r[30:23]) && !(|p4_r[22:0]);
    b_inf = (&bias_r[30:23]) && !(|bias_r[22:0]);
    aae   = (aa[30:23] == 8'd0) ? 8'd1 : aa[30:23];
    abe   = (ab[30:23] == 8'd0) ? 8'd1 : ab[30:23];
    aam   = {aa[30:23] != 8'd0, aa[22:0]};
    abm   = {ab[30:23] != 8'd0, ab[22:0]};
    ad    = aae - abe;
    adc   = (ad > 8'd31) ? 5'd31 : ad[4:0];
    abx   = {abm, 3'd0, 32'd0} >> adc;
    absh  = {abx[58:33], abx[32] | (|abx[31:0])};
    if (aa[31] == ab[31]) begin
      asum = {1'b0, aam, 3'd0} + {1'b0, absh};
    end else begin
      asum = {1'b0, aam, 3'd0} - {1'b0, absh};
    end
    a_spec = 1'b1;
    if (a_nan || b_nan || (a_inf && b_inf && (p4_r[31] != bias_r[31]))) begin
      a_specb = ssfc_pkg::QNAN;
    end else if (a_inf) begin
      a_specb = p4_r;
    end else if (b_inf) begin
      a_specb = bias_r;
    end else if (asum == 28'd0) begin
      // An exact zero sum is negative only when both addends are negative zeros.
      a_specb = {p4_r[31] & bias_r[31], 31'd0};
    end else begin
      a_spec  = 1'b0;
      a_specb = 32'd0;
    end
  end

  logic [5:0]  a_lead;
  logic [31:0] sum_bits;
  logic [31:0] val_bits;
  assign a_lead = ssfc_pkg::lead48(s5_r);

  always_comb begin
    sum_bits = asp6_r ? asb6_r : ssfc_pkg::round_pack(as6_r, n6_r, ne6_r);
    // Any NaN leaves as the canonical quiet NaN.
    if ((&sum_bits[30:23]) && (|sum_bits[22:0])) begin
      val_bits = ssfc_pkg::QNAN;
    end else begin
      val_bits = sum_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1.
      k1_r  <= in_data.kind;
      r1_r  <= !in_data.kind && (in_data.sample_index >= count_r);
      ip1_r <= in_data.sample_index * stride_r;
      x1_r  <= ssfc_pkg::convert_raw(format_r, in_data.raw_element);
      // Stage 2.
      k2_r   <= k1_r;
      r2_r   <= r1_r;
      el2_r  <= {32'd0, first_r} + {16'd0, ip1_r};
      ms2_r  <= m_sign;
      msp2_r <= m_spec;
      msb2_r <= m_specb;
      mp2_r  <= mxm * mgm;
      me2_r  <= m_ebase;
      // Stage 3.
      k3_r   <= k2_r;
      r3_r   <= r2_r;
      a3_r   <= {32'd0, header_r} + (el2_r << ssfc_pkg::size_shift(format_r));
      ms3_r  <= ms2_r;
      msp3_r <= msp2_r;
      msb3_r <= msb2_r;
      mn3_r  <= mp2_r << (6'd47 - m_lead);
      mne3_r <= me2_r + $signed({6'd0, m_lead});
      // Stage 4.
      k4_r <= k3_r;
      r4_r <= r3_r;
      a4_r <= a3_r;
      p4_r <= msp3_r ? msb3_r : ssfc_pkg::round_pack(ms3_r, mn3_r, mne3_r);
      // Stage 5.
      k5_r   <= k4_r;
      r5_r   <= r4_r;
      a5_r   <= a4_r;
      as5_r  <= aa[31];
      asp5_r <= a_spec;
      asb5_r <= a_specb;
      s5_r   <= {20'd0, asum};
      ae5_r  <= $signed({4'd0, aae}) - 12'sd26;
      // Stage 6.
      k6_r   <= k5_r;
      r6_r   <= r5_r;
      a6_r   <= a5_r;
      as6_r  <= as5_r;
      asp6_r <= asp5_r;
      asb6_r <= asb5_r;
      n6_r   <= s5_r << (6'd47 - a_lead);
      ne6_r  <= ae5_r + $signed({6'd0, a_lead});
      // Stage 7: assemble the result.
      out_data_r.is_value     <= k6_r;
      out_data_r.beyond_count <= r6_r;
      out_data_r.byte_address <= (k6_r || r6_r) ? 64'd0 : a6_r;
      out_data_r.value_bits   <= k6_r ? val_bits : 32'd0;
    end
  end

endmodule

// ----- rtl/core/ssfc_checker.sv -----
// Port-level checker for the strided sample fetch and convert unit, with the
// bind that attaches it. Depends on ssfc_pkg and the top level.
`timescale 1ns / 1ps

module ssfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ssfc_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("request refused with free output");

  a_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_value |-> out_data.byte_address == 64'd0 &&
      !out_data.beyond_count)
    else $error("value result carries address fields");

  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_value |-> out_data.value_bits == 32'd0 &&
      (!out_data.beyond_count || out_data.byte_address == 64'd0))
    else $error("address result malformed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind strided_sample_fetch_convert_unit ssfc_checker u_ssfc_checker (.*);
